// ----- sv/rgt_pkg.sv -----
`timescale 1ns / 1ps

package rgt_pkg;

	localparam int ALT_W    = 32;
	localparam int OUT_W    = 32;
	localparam int STEP_W   = 31;
	localparam int COLS_W   = 13;
	localparam int ROWS_W   = 16;
	localparam int CFG_IX_W = 3;
	localparam int CFG_D_W  = 32;

	typedef enum logic [CFG_IX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_STEP_X   = 3'd2,
		REG_STEP_Y   = 3'd3,
		REG_COLUMNS  = 3'd4,
		REG_ROWS     = 3'd5,
		REG_NODATA   = 3'd6
	} cfg_reg_t;

	localparam logic signed [ALT_W-1:0] ORIGIN_RST = '0;
	localparam logic [STEP_W-1:0]       STEP_RST   = 31'd256;
	localparam logic [COLS_W-1:0]       COLS_RST   = 13'd4096;
	localparam logic [ROWS_W-1:0]       ROWS_RST   = 16'd4096;
	localparam logic signed [ALT_W-1:0] NODATA_RST = -32'sd2559744;

endpackage

// ----- sv/rgt_ifs.sv -----
`timescale 1ns / 1ps

interface rgt_cfg_if import rgt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CFG_IX_W-1:0] index;
	logic [CFG_D_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

interface rgt_alt_if import rgt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ALT_W-1:0] altitude;

	modport source(output valid, altitude, input ready);
	modport sink(input valid, altitude, output ready);
endinterface

interface rgt_tri_if import rgt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] vertex_a_x;
	logic signed [OUT_W-1:0] vertex_a_y;
	logic signed [OUT_W-1:0] vertex_a_z;
	logic signed [OUT_W-1:0] vertex_b_x;
	logic signed [OUT_W-1:0] vertex_b_y;
	logic signed [OUT_W-1:0] vertex_b_z;
	logic signed [OUT_W-1:0] vertex_c_x;
	logic signed [OUT_W-1:0] vertex_c_y;
	logic signed [OUT_W-1:0] vertex_c_z;
	logic                    lower_triangle;
	logic                    last_of_run;

	modport source(
		output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
			vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, lower_triangle, last_of_run,
		input ready
	);
	modport sink(
		input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
			vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, lower_triangle, last_of_run,
		output ready
	);
endinterface

// ----- sv/raster_grid_triangulator.sv -----
`timescale 1ns / 1ps

// channel     dir  payload                                  beat
// cfg         in   index, data                              one register write
// samples     in   altitude                                 one grid sample
// triangles   out  vertex_a/b/c x,y,z, lower, last_of_run   one triangle
//
// The first triangle of a sample leaves through the row-store read, multiply, add
// and saturate stages, in that order, after the sample is accepted.
// One sample per cycle while triangles are not stalled and each sample gives at
// most one triangle; a cell with both holds the output stage until both are sent.
// Row store: 2 reads and at most 1 write per sample, no clearing pass after reset.
// Stalls on triangles back up through the stages; a dropped cell never stalls samples.

module raster_grid_triangulator import rgt_pkg::*; #(
	parameter int MAX_COLUMNS = 4096,
	parameter int COORD_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	rgt_cfg_if.sink    cfg,
	rgt_alt_if.sink    samples,
	rgt_tri_if.source  triangles
);

	localparam int AW    = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int XP_W  = AW + STEP_W;
	localparam int YP_W  = ROWS_W + STEP_W;
	localparam int SUM_W = ((XP_W > YP_W) ? XP_W : YP_W) + 2;
	localparam int EXT_W = ((COORD_WIDTH >= SUM_W) ? COORD_WIDTH : SUM_W) + 1;
	localparam logic signed [EXT_W-1:0] SAT_HI =
		$signed({EXT_W{1'b1}} >> (EXT_W - COORD_WIDTH + 1));
	localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

	function automatic logic [OUT_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
		logic signed [EXT_W-1:0] w;
		w = EXT_W'(v);
		priority if (w > SAT_HI) return SAT_HI[OUT_W-1:0];
		else if (w < SAT_LO) return SAT_LO[OUT_W-1:0];
		else return w[OUT_W-1:0];
	endfunction

	// configuration
	logic signed [ALT_W-1:0] origin_x_q, origin_y_q, nodata_q;
	logic [STEP_W-1:0]       step_x_q, step_y_q;
	logic [COLS_W-1:0]       columns_q;
	logic [ROWS_W-1:0]       rows_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= ORIGIN_RST;
			origin_y_q <= ORIGIN_RST;
			step_x_q   <= STEP_RST;
			step_y_q   <= STEP_RST;
			columns_q  <= COLS_RST;
			rows_q     <= ROWS_RST;
			nodata_q   <= NODATA_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ORIGIN_X: origin_x_q <= $signed(cfg.data);
				REG_ORIGIN_Y: origin_y_q <= $signed(cfg.data);
				REG_STEP_X:   step_x_q   <= cfg.data[STEP_W-1:0];
				REG_STEP_Y:   step_y_q   <= cfg.data[STEP_W-1:0];
				REG_COLUMNS:  columns_q  <= cfg.data[COLS_W-1:0];
				REG_ROWS:     rows_q     <= cfg.data[ROWS_W-1:0];
				REG_NODATA:   nodata_q   <= $signed(cfg.data);
				default: ;
			endcase
		end
	end

	logic [CNT_W-1:0]  ecol;
	logic [ROWS_W-1:0] erow;

	always_comb begin
		if (columns_q < COLS_W'(2)) ecol = CNT_W'(2);
		else if (32'(columns_q) > MAX_COLUMNS) ecol = CNT_W'(MAX_COLUMNS);
		else ecol = CNT_W'(columns_q);
		erow = (rows_q < ROWS_W'(2)) ? ROWS_W'(2) : rows_q;
	end

	// stage control
	logic v_s1, v_s2, v_s3, v_s4;
	logic e0_s4, e1_s4;
	logic keep1, rdy1, rdy2, rdy3, ld4, last4, acc, out_fire;

	// sample intake, counters, row store
	logic [CNT_W-1:0]  colcnt_q, c, c_nxt;
	logic [ROWS_W-1:0] rowcnt_q, r;
	logic [ALT_W-1:0]  left_q, tail_d_q;
	logic [AW-1:0]     tail_a_q, wa;
	logic              tail_v_q, we;
	logic [ALT_W-1:0]  wd;
	logic [ALT_W-1:0]  row_mem [MAX_COLUMNS];

	assign acc = samples.valid && samples.ready;

	always_comb begin
		c = colcnt_q;
		r = rowcnt_q;
		if (colcnt_q >= ecol) begin
			c = '0;
			r = ROWS_W'(rowcnt_q + 1'b1);
		end
		if (r >= erow) r = '0;
		c_nxt = CNT_W'(c + 1'b1);
		we = acc && (c != '0 || tail_v_q);
		wa = (c != '0) ? AW'(c - 1'b1) : tail_a_q;
		wd = (c != '0) ? left_q : tail_d_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colcnt_q <= '0;
			rowcnt_q <= '0;
			left_q   <= '0;
			tail_v_q <= 1'b0;
		end else if (acc) begin
			left_q <= samples.altitude;
			if (c_nxt >= ecol) begin
				colcnt_q <= '0;
				rowcnt_q <= (ROWS_W'(r + 1'b1) >= erow) ? '0 : ROWS_W'(r + 1'b1);
				tail_v_q <= 1'b1;
			end else begin
				colcnt_q <= c_nxt;
				rowcnt_q <= r;
				tail_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && c_nxt >= ecol) begin
			tail_a_q <= c[AW-1:0];
			tail_d_q <= samples.altitude;
		end
	end

	// stage 1: row-store read data
	logic [ALT_W-1:0]  ul_s1, ur_s1, ll_s1, lr_s1;
	logic [AW-1:0]     xi_s1;
	logic [ROWS_W-1:0] yi_s1;
	logic              cell_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			ul_s1 <= row_mem[AW'(c - 1'b1)];
			ur_s1 <= row_mem[c[AW-1:0]];
		end
		if (we) row_mem[wa] <= wd;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ll_s1   <= left_q;
			lr_s1   <= samples.altitude;
			xi_s1   <= AW'(c - 1'b1);
			yi_s1   <= ROWS_W'(erow - r - 1'b1);
			cell_s1 <= (c != '0) && (r != '0);
		end
	end

	logic e0_1, e1_1;

	always_comb begin
		e0_1  = cell_s1 && ul_s1 != nodata_q && ll_s1 != nodata_q && ur_s1 != nodata_q;
		e1_1  = cell_s1 && ur_s1 != nodata_q && ll_s1 != nodata_q && lr_s1 != nodata_q;
		keep1 = e0_1 || e1_1;
	end

	assign last4    = !(e0_s4 && e1_s4);
	assign out_fire = triangles.valid && triangles.ready;
	assign ld4      = !v_s4 || (out_fire && last4);
	assign rdy3     = !v_s3 || ld4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || !keep1 || rdy2;
	assign samples.ready = rdy1;

	// stage 2: products
	logic [XP_W-1:0]  px_s2;
	logic [YP_W-1:0]  py_s2;
	logic [ALT_W-1:0] ul_s2, ur_s2, ll_s2, lr_s2;
	logic             e0_s2, e1_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			px_s2 <= XP_W'(xi_s1) * XP_W'(step_x_q);
			py_s2 <= YP_W'(yi_s1) * YP_W'(step_y_q);
			ul_s2 <= ul_s1;
			ur_s2 <= ur_s1;
			ll_s2 <= ll_s1;
			lr_s2 <= lr_s1;
			e0_s2 <= e0_1;
			e1_s2 <= e1_1;
		end
	end

	// stage 3: sums
	logic signed [SUM_W-1:0] xmin_s3, xmax_s3, ymin_s3, ymax_s3;
	logic [ALT_W-1:0]        ul_s3, ur_s3, ll_s3, lr_s3;
	logic                    e0_s3, e1_s3;
	logic signed [SUM_W-1:0] ox_w, oy_w, px_w, py_w, sx_w, sy_w;

	always_comb begin
		ox_w = SUM_W'(origin_x_q);
		oy_w = SUM_W'(origin_y_q);
		px_w = $signed(SUM_W'(px_s2));
		py_w = $signed(SUM_W'(py_s2));
		sx_w = $signed(SUM_W'(step_x_q));
		sy_w = $signed(SUM_W'(step_y_q));
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			xmin_s3 <= ox_w + px_w;
			xmax_s3 <= ox_w + px_w + sx_w;
			ymin_s3 <= oy_w + py_w;
			ymax_s3 <= oy_w + py_w + sy_w;
			ul_s3   <= ul_s2;
			ur_s3   <= ur_s2;
			ll_s3   <= ll_s2;
			lr_s3   <= lr_s2;
			e0_s3   <= e0_s2;
			e1_s3   <= e1_s2;
		end
	end

	// stage 4: saturated cell, one or two beats out
	logic [OUT_W-1:0] xmin_s4, xmax_s4, ymin_s4, ymax_s4;
	logic [ALT_W-1:0] ul_s4, ur_s4, ll_s4, lr_s4;

	always_ff @(posedge clk) begin
		if (ld4) begin
			xmin_s4 <= sat_coord(xmin_s3);
			xmax_s4 <= sat_coord(xmax_s3);
			ymin_s4 <= sat_coord(ymin_s3);
			ymax_s4 <= sat_coord(ymax_s3);
			ul_s4   <= ul_s3;
			ur_s4   <= ur_s3;
			ll_s4   <= ll_s3;
			lr_s4   <= lr_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			e0_s4 <= 1'b0;
			e1_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= acc;
			if (rdy2) v_s2 <= v_s1 && keep1;
			if (rdy3) v_s3 <= v_s2;
			if (ld4) begin
				v_s4  <= v_s3;
				e0_s4 <= v_s3 && e0_s3;
				e1_s4 <= v_s3 && e1_s3;
			end else if (out_fire) begin
				e0_s4 <= 1'b0;
			end
		end
	end

	logic sel1;

	assign sel1 = !e0_s4;

	assign triangles.valid          = v_s4;
	assign triangles.vertex_a_x     = sel1 ? xmax_s4 : xmin_s4;
	assign triangles.vertex_a_y     = ymax_s4;
	assign triangles.vertex_a_z     = sel1 ? ur_s4 : ul_s4;
	assign triangles.vertex_b_x     = xmin_s4;
	assign triangles.vertex_b_y     = ymin_s4;
	assign triangles.vertex_b_z     = ll_s4;
	assign triangles.vertex_c_x     = xmax_s4;
	assign triangles.vertex_c_y     = sel1 ? ymin_s4 : ymax_s4;
	assign triangles.vertex_c_z     = sel1 ? lr_s4 : ur_s4;
	assign triangles.lower_triangle = sel1;
	assign triangles.last_of_run    = last4;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import rgt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASES = 12;

	typedef struct packed {
		logic [31:0] ax, ay, az;
		logic [31:0] bx, by, bz;
		logic [31:0] cx, cy, cz;
		logic        lower;
		logic        last;
	} tri_t;

	typedef enum logic {ROW_REG, ROW_ALT} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		cfg_reg_t    ix;
		logic [31:0] val;
		bit          typed;
		int          n;
		tri_t        t0;
		tri_t        t1;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_cnt = 0;
	int   bad_cnt = 0;
	bit   no_idle;

	rgt_cfg_if cfg_bus();
	rgt_alt_if alt_bus();
	rgt_tri_if tri_bus();

	raster_grid_triangulator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_bus),
		.samples   (alt_bus),
		.triangles (tri_bus)
	);

	// grid mirror
	longint      grid_org_x, grid_org_y, grid_stp_x, grid_stp_y;
	int          grid_cols, grid_rows;
	logic [31:0] grid_nodata;
	logic [31:0] line_buf [4096];
	logic [31:0] prev_alt;
	int          col_cnt, row_cnt;
	tri_t        owed_tris [$];
	plan_row_t   plan [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic void owe_tri(tri_t t);
		owed_tris.insert(owed_tris.size(), t);
	endfunction

	function automatic void add_row(plan_row_t pr);
		plan.insert(plan.size(), pr);
	endfunction

	function automatic logic [31:0] clip(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic string fmt_tri(tri_t t);
		return $sformatf("a(%h %h %h) b(%h %h %h) c(%h %h %h) lower %b last %b",
			t.ax, t.ay, t.az, t.bx, t.by, t.bz, t.cx, t.cy, t.cz, t.lower, t.last);
	endfunction

	task automatic note_bad(string msg);
		bad_cnt++;
		if (bad_cnt <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic apply_reg(cfg_reg_t ix, logic [31:0] d);
		case (ix)
			REG_ORIGIN_X: grid_org_x = longint'(signed'(d));
			REG_ORIGIN_Y: grid_org_y = longint'(signed'(d));
			REG_STEP_X:   grid_stp_x = longint'(d[30:0]);
			REG_STEP_Y:   grid_stp_y = longint'(d[30:0]);
			REG_COLUMNS:  grid_cols = int'(d[12:0]);
			REG_ROWS:     grid_rows = int'(d[15:0]);
			REG_NODATA:   grid_nodata = d;
			default: ;
		endcase
	endtask

	// Cell closing: a sample at column >= 1 of row >= 1 gives up to two triangles.
	task automatic triangulate(logic [31:0] z, bit keep);
		int          ecol, erow, c, r;
		logic [31:0] ul, ur, ll;
		longint      xmin, xmax, ymax, ymin;
		bit          up_ok, dn_ok;
		ecol = (grid_cols < 2) ? 2 : ((grid_cols > 4096) ? 4096 : grid_cols);
		erow = (grid_rows < 2) ? 2 : grid_rows;
		if (col_cnt >= ecol) begin
			col_cnt = 0;
			row_cnt++;
		end
		if (row_cnt >= erow)
			row_cnt = 0;
		c = col_cnt;
		r = row_cnt;
		if (c >= 1) begin
			ul = line_buf[c - 1];
			ur = line_buf[c];
			ll = prev_alt;
			if (r >= 1) begin
				xmin = grid_org_x + longint'(c - 1) * grid_stp_x;
				xmax = grid_org_x + longint'(c) * grid_stp_x;
				ymax = grid_org_y + longint'(erow - r) * grid_stp_y;
				ymin = grid_org_y + longint'(erow - r - 1) * grid_stp_y;
				up_ok = (ul != grid_nodata) && (ll != grid_nodata) && (ur != grid_nodata);
				dn_ok = (ur != grid_nodata) && (ll != grid_nodata) && (z != grid_nodata);
				if (keep && up_ok)
					owe_tri({clip(xmin), clip(ymax), ul, clip(xmin), clip(ymin), ll,
						clip(xmax), clip(ymax), ur, 1'b0, ~dn_ok});
				if (keep && dn_ok)
					owe_tri({clip(xmax), clip(ymax), ur, clip(xmin), clip(ymin), ll,
						clip(xmax), clip(ymin), z, 1'b1, 1'b1});
			end
			line_buf[c - 1] = prev_alt;
		end
		if (c + 1 >= ecol)
			line_buf[c] = z;
		prev_alt = z;
		col_cnt = c + 1;
		if (col_cnt >= ecol) begin
			col_cnt = 0;
			row_cnt = r + 1;
			if (row_cnt >= erow)
				row_cnt = 0;
		end
	endtask

	task automatic push_alt(logic [31:0] z);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			alt_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		alt_bus.altitude = z;
		alt_bus.valid = 1'b1;
		@(posedge clk);
		while (!alt_bus.ready) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t ix, logic [31:0] d);
		@(negedge clk);
		cfg_bus.index = ix;
		cfg_bus.data = d;
		cfg_bus.valid = 1'b1;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		apply_reg(ix, d);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		alt_bus.valid = 1'b0;
		while (owed_tris.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic feed(logic [31:0] z);
		push_alt(z);
		triangulate(z, 1'b1);
	endtask

	function automatic logic [31:0] draw_altitude();
		case ($urandom_range(0, 15))
			0, 1: return grid_nodata;
			2: return 32'h7fffffff;
			3: return 32'h80000000;
			4, 5, 6: return $urandom_range(0, 2048) - 1024;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] draw_origin();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			3: return $urandom;
			default: return $urandom_range(0, 131072) - 65536;
		endcase
	endfunction

	function automatic logic [31:0] draw_step();
		logic [31:0] d;
		d = $urandom;
		case ($urandom_range(0, 4))
			0: d[30:0] = 31'd256;
			1: d[30:0] = 31'($urandom_range(1, 4096));
			2: d[30:0] = 31'h7fffffff;
			3: d[30:0] = 31'd1;
			default: d[30:0] = 31'($urandom);
		endcase
		if (d[30:0] == 0)
			d[30:0] = 31'd1;
		return d;
	endfunction

	// Brings the grid back to a frame start before widths change, so row 1 never reads a stale line entry.
	task automatic to_frame_start();
		if (!(col_cnt == 0 && row_cnt == 0)) begin
			settle();
			write_reg(REG_ROWS, 32'd2);
			while (!(col_cnt == 0 && row_cnt == 0))
				feed(draw_altitude());
		end
		settle();
	endtask

	initial begin
		tri_t got;
		tri_t want;
		int   gap;
		tri_bus.ready = 1'b0;
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 4);
			@(negedge clk);
			if (gap > 0) begin
				tri_bus.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			tri_bus.ready = 1'b1;
			@(posedge clk);
			while (!tri_bus.valid) @(posedge clk);
			got = {tri_bus.vertex_a_x, tri_bus.vertex_a_y, tri_bus.vertex_a_z,
				tri_bus.vertex_b_x, tri_bus.vertex_b_y, tri_bus.vertex_b_z,
				tri_bus.vertex_c_x, tri_bus.vertex_c_y, tri_bus.vertex_c_z,
				tri_bus.lower_triangle, tri_bus.last_of_run};
			if (owed_tris.size() == 0) begin
				note_bad({"unexpected triangle ", fmt_tri(got)});
			end else begin
				want = owed_tris.pop_front();
				if (got !== want)
					note_bad({"triangle mismatch\n  expected ", fmt_tri(want),
						"\n  actual   ", fmt_tri(got)});
			end
		end
	end

	initial begin
		plan_row_t   pr;
		logic [31:0] d;
		int          n;
		arst_n = 1'b0;
		no_idle = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		alt_bus.valid = 1'b0;
		alt_bus.altitude = '0;

		grid_org_x = longint'(ORIGIN_RST);
		grid_org_y = longint'(ORIGIN_RST);
		grid_stp_x = longint'(STEP_RST);
		grid_stp_y = longint'(STEP_RST);
		grid_cols = int'(COLS_RST);
		grid_rows = int'(ROWS_RST);
		grid_nodata = NODATA_RST;
		prev_alt = '0;
		col_cnt = 0;
		row_cnt = 0;
		foreach (line_buf[i])
			line_buf[i] = '0;

		// reset settings, row 0: nothing closes
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'h0, 1'b1, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'h7fffffff, 1'b1, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'h80000000, 1'b1, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, NODATA_RST, 1'b1, 0, '0, '0});
		// shrink mid-row: column counter wraps into row 1
		add_row(plan_row_t'{ROW_REG, REG_COLUMNS, 32'd2, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_REG, REG_ROWS, 32'd2, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd100, 1'b1, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'hffffff9c, 1'b1, 2,
			tri_t'({32'h0, 32'h100, 32'h0, 32'h0, 32'h0, 32'd100,
				32'h100, 32'h100, 32'h7fffffff, 1'b0, 1'b0}),
			tri_t'({32'h100, 32'h100, 32'h7fffffff, 32'h0, 32'h0, 32'd100,
				32'h100, 32'h0, 32'hffffff9c, 1'b1, 1'b1})});
		// extreme settings: saturated x, clamped sizes, nodata zero
		add_row(plan_row_t'{ROW_REG, REG_ORIGIN_X, 32'h7fffffff, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_REG, REG_ORIGIN_Y, 32'h80000000, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_REG, REG_STEP_X, 32'h7fffffff, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_REG, REG_STEP_Y, 32'hffffffff, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_REG, REG_COLUMNS, 32'd1, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_REG, REG_ROWS, 32'd0, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_REG, REG_NODATA, 32'h0, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd5, 1'b1, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd6, 1'b1, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd7, 1'b1, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd8, 1'b1, 2,
			tri_t'({32'h7fffffff, 32'hffffffff, 32'd5, 32'h7fffffff, 32'h80000000, 32'd7,
				32'h7fffffff, 32'hffffffff, 32'd6, 1'b0, 1'b0}),
			tri_t'({32'h7fffffff, 32'hffffffff, 32'd6, 32'h7fffffff, 32'h80000000, 32'd7,
				32'h7fffffff, 32'h80000000, 32'd8, 1'b1, 1'b1})});
		// nodata in upper-left, lower-right, lower-left
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd0, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd9, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd10, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd11, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd1, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd2, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd3, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd0, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd1, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd2, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd0, 1'b0, 0, '0, '0});
		add_row(plan_row_t'{ROW_ALT, REG_ORIGIN_X, 32'd3, 1'b0, 0, '0, '0});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			pr = plan[i];
			if (pr.kind == ROW_REG) begin
				settle();
				write_reg(pr.ix, pr.val);
			end else begin
				push_alt(pr.val);
				triangulate(pr.val, !pr.typed);
				if (pr.typed && pr.n > 0)
					owe_tri(pr.t0);
				if (pr.typed && pr.n > 1)
					owe_tri(pr.t1);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			no_idle = 1'b0;
			to_frame_start();
			write_reg(REG_ORIGIN_X, draw_origin());
			write_reg(REG_ORIGIN_Y, draw_origin());
			write_reg(REG_STEP_X, draw_step());
			write_reg(REG_STEP_Y, draw_step());
			d = $urandom;
			case ($urandom_range(0, 7))
				0: d[12:0] = 13'($urandom_range(0, 1));
				1: d[12:0] = 13'($urandom_range(13, 40));
				default: d[12:0] = 13'($urandom_range(2, 12));
			endcase
			write_reg(REG_COLUMNS, d);
			d = $urandom;
			case ($urandom_range(0, 7))
				0: d[15:0] = 16'($urandom_range(0, 1));
				1: d[15:0] = 16'hffff;
				2: d[15:0] = 16'($urandom_range(7, 65535));
				default: d[15:0] = 16'($urandom_range(2, 6));
			endcase
			write_reg(REG_ROWS, d);
			case ($urandom_range(0, 3))
				0: write_reg(REG_NODATA, NODATA_RST);
				1: write_reg(REG_NODATA, $urandom);
				default: write_reg(REG_NODATA, $urandom_range(0, 2048) - 1024);
			endcase
			if (ph == 5) begin
				// oversize width, then shrink past the current column
				d = $urandom;
				case ($urandom_range(0, 2))
					0: d[12:0] = 13'd4096;
					1: d[12:0] = 13'd4097;
					default: d[12:0] = 13'h1fff;
				endcase
				write_reg(REG_COLUMNS, d);
				write_reg(REG_ROWS, 32'd3);
				repeat (10)
					feed(draw_altitude());
				settle();
				write_reg(REG_COLUMNS, 32'd3);
			end
			no_idle = ($urandom_range(0, 3) == 0);
			n = $urandom_range(60, 90);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 39) == 0)
					settle();
				feed(draw_altitude());
			end
		end

		settle();
		if (bad_cnt == 0 && owed_tris.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
